/* design/dtd_pkg.sv */
// Package for the double tap detector: field widths, kind and verdict codes,
// register reset values and the shared item and config structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

    localparam int FINGER_W  = 13;
    localparam int TICKS_W   = 16;
    localparam int WINDOW_W  = 16;
    localparam int OFFSET_W  = 13;
    localparam int SINCE_W   = 16;
    localparam int KIND_W    = 2;
    localparam int VERDICT_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    // Manhattan length: two magnitudes of up to 4096 each
    localparam int LEN_W     = OFFSET_W + 1;

    // Register reset values (timeout of 0.33 s in 1 ms ticks)
    localparam logic [FINGER_W-1:0] TAP_SLOP_RST     = FINGER_W'(10);
    localparam logic [TICKS_W-1:0]  TAP_TIMEOUT_RST  = TICKS_W'(330);
    localparam logic [WINDOW_W-1:0] COMBINE_WIN_RST  = WINDOW_W'(100);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SLOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_WIN = 2'd2;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] V_CANCEL  = 3'd0;
    localparam logic [VERDICT_W-1:0] V_TRIGGER = 3'd1;
    localparam logic [VERDICT_W-1:0] V_FINISH  = 3'd2;
    localparam logic [VERDICT_W-1:0] V_IGNORE  = 3'd3;
    localparam logic [VERDICT_W-1:0] V_TIMEOUT = 3'd4;
    localparam logic [VERDICT_W-1:0] V_NOTHING = 3'd5;

    typedef struct packed {
        logic [FINGER_W-1:0] tap_slop;
        logic [TICKS_W-1:0]  tap_timeout_ticks;
        logic [WINDOW_W-1:0] combine_window;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [OFFSET_W-1:0] dx;
        logic signed [OFFSET_W-1:0] dy;
        logic                       pointer_down;
        logic                       prev_lifted;
        logic [SINCE_W-1:0]         since_gesture;
        logic                       gesture_active;
        logic                       multi_touch;
    } t_item;

    // Magnitude of a 13-bit two's complement offset; -4096 gives 4096
    function automatic logic [OFFSET_W-1:0] abs_off(input logic [OFFSET_W-1:0] v);
        logic [OFFSET_W-1:0] neg;
        neg = (~v) + OFFSET_W'(1);
        return v[OFFSET_W-1] ? neg : v;
    endfunction

endpackage

`default_nettype wire

/* design/dtd_cfg.sv */
// Configuration register file of the double tap detector.
// Depends on dtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtd_cfg import dtd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_slop          <= TAP_SLOP_RST;
            r_cfg.tap_timeout_ticks <= TAP_TIMEOUT_RST;
            r_cfg.combine_window    <= COMBINE_WIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAP_SLOP:    r_cfg.tap_slop          <= i_cfg_data[FINGER_W-1:0];
                CFG_TAP_TIMEOUT: r_cfg.tap_timeout_ticks <= i_cfg_data[TICKS_W-1:0];
                CFG_COMBINE_WIN: r_cfg.combine_window    <= i_cfg_data[WINDOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/dtd_eval.sv */
// Tap state (tap count, timer) and the per-word verdict logic.
// Depends on dtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtd_eval import dtd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_commit,
    input  t_item                      i_item,
    input  t_cfg                       i_cfg,
    output logic [VERDICT_W-1:0]       o_verdict
);

    logic               r_first_tap_seen;
    logic               r_timer_running;
    logic [TICKS_W-1:0] r_ticks_left;
    logic               n_first_tap_seen;
    logic               n_timer_running;
    logic [TICKS_W-1:0] n_ticks_left;

    logic [LEN_W-1:0]   len;
    logic               in_window;
    logic               near;

    // Manhattan movement and window compare
    assign len = LEN_W'(abs_off(i_item.dx)) + LEN_W'(abs_off(i_item.dy));
    assign near = (len <= LEN_W'(i_cfg.tap_slop));
    assign in_window = (i_item.since_gesture < i_cfg.combine_window);

    // Decide the verdict and the next state
    always_comb begin
        n_first_tap_seen = r_first_tap_seen;
        n_timer_running  = r_timer_running;
        n_ticks_left     = r_ticks_left;
        o_verdict        = V_NOTHING;
        case (i_item.kind)
            KIND_TICK: begin
                if (r_timer_running) begin
                    if (r_ticks_left <= TICKS_W'(1)) begin
                        n_first_tap_seen = 1'b0;
                        n_timer_running  = 1'b0;
                        n_ticks_left     = '0;
                        o_verdict        = V_TIMEOUT;
                    end else begin
                        n_ticks_left = r_ticks_left - TICKS_W'(1);
                    end
                end
            end
            KIND_BEGIN: begin
                n_timer_running = 1'b1;
                n_ticks_left    = i_cfg.tap_timeout_ticks;
                o_verdict       = V_TRIGGER;
            end
            KIND_UPDATE: begin
                o_verdict = V_IGNORE;
                if (!(i_item.pointer_down && in_window) && i_item.gesture_active &&
                    !i_item.multi_touch && !near) begin
                    n_first_tap_seen = 1'b0;
                    n_timer_running  = 1'b0;
                    n_ticks_left     = '0;
                    o_verdict        = V_CANCEL;
                end
            end
            KIND_END: begin
                o_verdict = V_CANCEL;
                if (i_item.gesture_active && !i_item.multi_touch) begin
                    if (i_item.prev_lifted && in_window) begin
                        o_verdict = V_IGNORE;
                    end else if (near && !r_first_tap_seen) begin
                        // first tap: count it, rearm a running timer
                        n_first_tap_seen = 1'b1;
                        if (r_timer_running) begin
                            n_ticks_left = i_cfg.tap_timeout_ticks;
                        end
                        o_verdict = V_TRIGGER;
                    end else begin
                        // second tap finishes, a long move cancels; both clear
                        n_first_tap_seen = 1'b0;
                        n_timer_running  = 1'b0;
                        n_ticks_left     = '0;
                        o_verdict        = near ? V_FINISH : V_CANCEL;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Advance state once per committed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_tap_seen <= 1'b0;
            r_timer_running  <= 1'b0;
            r_ticks_left     <= '0;
        end else if (i_commit) begin
            r_first_tap_seen <= n_first_tap_seen;
            r_timer_running  <= n_timer_running;
            r_ticks_left     <= n_ticks_left;
        end
    end

    // A stopped timer always holds zero ticks
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timer_running |-> (r_ticks_left == '0))
        else $error("timer stopped with ticks left");

    // A committed timeout leaves everything cleared
    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && o_verdict == V_TIMEOUT) |=> (!r_timer_running && !r_first_tap_seen))
        else $error("timeout did not clear state");

    // A committed touch begin starts the timer
    a_begin_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && i_item.kind == KIND_BEGIN) |=> r_timer_running)
        else $error("touch begin did not start timer");

    // Finish only happens after a counted first tap
    a_finish_after_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && o_verdict == V_FINISH) |-> r_first_tap_seen)
        else $error("finish without first tap");

endmodule

`default_nettype wire

/* design/double_tap_detector.sv */
// Top level of the double tap detector: input word register, verdict
// register and handshakes. Depends on dtd_pkg, dtd_cfg and dtd_eval.
//
//   port group   dir  handshake                  payload
//   ----------   ---  -------------------------  ---------------------------------
//   input word   in   i_in_valid / o_in_ready    i_kind i_dx i_dy i_pointer_down
//                                                i_prev_lifted i_since_gesture
//                                                i_gesture_active i_multi_touch
//   verdict      out  o_out_valid / i_out_ready  o_verdict
//   config       in   i_cfg_we (no wait)         i_cfg_idx i_cfg_data
//
// One word per cycle sustained while the output is not stalled; the verdict
// is registered when the word moves on from the input register.
// The verdict logic and the state update sit combinationally between the two
// registers; state advances when a word moves into the verdict register.
// A stalled output holds the verdict and the input register; new words are
// taken while the input register is free or moving on.
// Reset is synchronous, active low, and clears state, valids and config registers.
`timescale 1ns / 1ps
`default_nettype none

module double_tap_detector import dtd_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0]       i_cfg_data,
    // input words
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [KIND_W-1:0]          i_kind,
    input  wire logic signed [OFFSET_W-1:0] i_dx,
    input  wire logic signed [OFFSET_W-1:0] i_dy,
    input  wire logic                       i_pointer_down,
    input  wire logic                       i_prev_lifted,
    input  wire logic [SINCE_W-1:0]         i_since_gesture,
    input  wire logic                       i_gesture_active,
    input  wire logic                       i_multi_touch,
    // verdicts
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [VERDICT_W-1:0]            o_verdict
);

    t_cfg                 cfg;
    t_item                r_item;
    logic                 r_item_valid;
    logic                 r_out_valid;
    logic [VERDICT_W-1:0] r_verdict;
    logic [VERDICT_W-1:0] eval_verdict;
    logic                 advance;
    logic                 in_take;

    dtd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Move a word into the verdict register when that slot is free or leaving
    assign advance    = r_item_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_item_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    dtd_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_verdict (eval_verdict)
    );

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
        if (in_take) begin
            r_item.kind           <= i_kind;
            r_item.dx             <= i_dx;
            r_item.dy             <= i_dy;
            r_item.pointer_down   <= i_pointer_down;
            r_item.prev_lifted    <= i_prev_lifted;
            r_item.since_gesture  <= i_since_gesture;
            r_item.gesture_active <= i_gesture_active;
            r_item.multi_touch    <= i_multi_touch;
        end
    end

    // Hold the verdict until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_verdict <= eval_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

`default_nettype wire
